// ----- rtl/drst_pkg.sv -----
// ----------------------------------------------------------------------------
// drst_pkg
// shared types, codes and helpers of the routing session tracker
// ----------------------------------------------------------------------------
package drst_pkg;

	// sizing
	localparam int SESSIONS   = 16;
	localparam int COUNT_BITS = 32;
	localparam int OUT_BITS   = 32;
	localparam int IDX_W      = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;

	typedef logic [IDX_W-1:0]      idx_t;
	typedef logic [COUNT_BITS-1:0] count_t;

	localparam count_t COUNT_ONE = count_t'(1);

	// message kinds
	localparam logic [2:0] OP_ROUTE_REQ  = 3'd0;
	localparam logic [2:0] OP_ROUTE_RESP = 3'd1;
	localparam logic [2:0] OP_DIAG_MSG   = 3'd2;
	localparam logic [2:0] OP_ACK_POS    = 3'd3;
	localparam logic [2:0] OP_ACK_NEG    = 3'd4;
	localparam logic [2:0] OP_ANNOUNCE   = 3'd5;
	localparam logic [2:0] OP_ALIVE_REQ  = 3'd6;

	// result status codes
	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_BAD_VER    = 3'd1;
	localparam logic [2:0] ST_TOO_SHORT  = 3'd2;
	localparam logic [2:0] ST_TABLE_FULL = 3'd3;
	localparam logic [2:0] ST_NO_MATCH   = 3'd4;

	// session link states
	localparam logic [2:0] LS_NONE       = 3'd0;
	localparam logic [2:0] LS_AWAIT_RESP = 3'd1;
	localparam logic [2:0] LS_AWAIT_CONF = 3'd2;
	localparam logic [2:0] LS_ACTIVE     = 3'd3;
	localparam logic [2:0] LS_FAILED     = 3'd4;

	// routing activation response codes
	localparam logic [7:0] CODE_ACTIVATED = 8'h10;
	localparam logic [7:0] CODE_CONFIRM   = 8'h11;

	// minimum payload lengths
	localparam logic [15:0] MIN_REQ_LEN  = 16'd7;
	localparam logic [15:0] MIN_RESP_LEN = 16'd9;
	localparam logic [15:0] MIN_DIAG_LEN = 16'd4;
	localparam logic [15:0] MIN_ACK_LEN  = 16'd5;
	localparam logic [15:0] MIN_ANN_LEN  = 16'd32;

	// statistics counter slots
	localparam int C_PACKET   = 0;
	localparam int C_REQUEST  = 1;
	localparam int C_RESPONSE = 2;
	localparam int C_DIAG     = 3;
	localparam int C_ALIVE    = 4;
	localparam int C_ANNOUNCE = 5;
	localparam int C_ERROR    = 6;
	localparam int N_COUNTERS = 7;

	typedef struct packed {
		logic [2:0]  op;
		logic [7:0]  version;
		logic [7:0]  inverse_version;
		logic [15:0] payload_len;
		logic [15:0] addr_first;
		logic [15:0] addr_second;
		logic [7:0]  code_byte;
	} msg_t;

	typedef struct packed {
		logic [2:0]          status;
		logic [2:0]          session_state;
		logic [OUT_BITS-1:0] diag_count;
		logic [OUT_BITS-1:0] packet_total;
		logic [OUT_BITS-1:0] request_total;
		logic [OUT_BITS-1:0] response_total;
		logic [OUT_BITS-1:0] diag_total;
		logic [OUT_BITS-1:0] alive_total;
		logic [OUT_BITS-1:0] announce_total;
		logic [OUT_BITS-1:0] error_total;
	} rpt_t;

	// controller to datapath commands
	typedef struct packed {
		logic load_in;
		logic lookup;
		logic commit;
	} cmd_t;

	function automatic count_t sat_inc(count_t v);
		return (v == '1) ? v : v + COUNT_ONE;
	endfunction

	function automatic logic [OUT_BITS-1:0] show(count_t v);
		return OUT_BITS'(v);
	endfunction

endpackage

// ----- rtl/doip_routing_session_tracker.sv -----
// ----------------------------------------------------------------------------
// doip_routing_session_tracker
// routing activation session table and message statistics for decoded messages
// ----------------------------------------------------------------------------
// usage
//   msg channel: one decoded message per item (msg_valid / msg_stall)
//   rpt channel: one result item per message (rpt_valid / rpt_stall)
//   an item moves at a rising edge with valid high and stall low
//   an accepted item is captured, then its lookup is registered, then the
//     commit loads the result register; a new item is taken only after the
//     commit (sequencer steps: capture, registered 16-way tester address
//     match, table and counter commit)
//   msg_stall is high while an item is in lookup or commit
//   a finished result sits in the output register; the next item is taken
//     meanwhile and waits in commit until the receiver drains the register
//   a stalled result holds its value until taken
//   reset clears the session valid bits and all statistics counters at
//     once; no clearing pass, the block takes items right after reset
//   counters saturate; the totals show the counts after each message
// ----------------------------------------------------------------------------
module doip_routing_session_tracker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           msg_valid,
	output logic           msg_stall,
	input  drst_pkg::msg_t msg,
	output logic           rpt_valid,
	input  logic           rpt_stall,
	output drst_pkg::rpt_t rpt
);
	import drst_pkg::*;

	// commands from sequencer to datapath
	cmd_t cmd;

	// sequencer: owns the handshakes and the output valid
	drst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.msg_valid (msg_valid),
		.msg_stall (msg_stall),
		.rpt_valid (rpt_valid),
		.rpt_stall (rpt_stall),
		.cmd       (cmd)
	);

	// datapath: session table, counters, result register
	drst_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.msg    (msg),
		.rpt    (rpt)
	);

`ifndef SYNTH
	// an accepted item keeps the input side busy in the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		msg_valid && !msg_stall |=> msg_stall)
		else $error("input not stalled after accept");

	// a new result only appears after a commit
	a_rise_needs_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rpt_valid) |-> $past(cmd.commit))
		else $error("result valid without commit");

	// a message that touches no session reports no session
	a_untouched_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rpt_valid && (rpt.status == ST_BAD_VER || rpt.status == ST_TABLE_FULL ||
		rpt.status == ST_NO_MATCH || rpt.status == ST_TOO_SHORT) |->
		rpt.session_state == LS_NONE && rpt.diag_count == '0)
		else $error("session fields set for untouched session");

	// commit never happens while a held result is still stalled
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		rpt_valid && rpt_stall |-> !cmd.commit)
		else $error("result overwritten while stalled");
`endif

endmodule

// ----- rtl/drst_ctrl.sv -----
// ----------------------------------------------------------------------------
// drst_ctrl
// sequencer: accept, address lookup, commit and result handoff
// ----------------------------------------------------------------------------
module drst_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          msg_valid,
	output logic          msg_stall,
	output logic          rpt_valid,
	input  logic          rpt_stall,
	output drst_pkg::cmd_t cmd
);
	import drst_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_LOOKUP,
		S_COMMIT
	} state_t;

	state_t state_q;
	logic   rpt_valid_q;
	logic   out_free;

	// output register can take a new item when empty or drained this cycle
	assign out_free = !rpt_valid_q || !rpt_stall;

	assign msg_stall   = (state_q != S_IDLE);
	assign rpt_valid   = rpt_valid_q;
	assign cmd.load_in = (state_q == S_IDLE) && msg_valid;
	assign cmd.lookup  = (state_q == S_LOOKUP);
	assign cmd.commit  = (state_q == S_COMMIT) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rpt_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				rpt_valid_q <= 1'b1;
			end else if (rpt_valid_q && !rpt_stall) begin
				rpt_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (msg_valid) begin
						state_q <= S_LOOKUP;
					end
				end
				S_LOOKUP: begin
					state_q <= S_COMMIT;
				end
				S_COMMIT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- rtl/drst_datapath.sv -----
// ----------------------------------------------------------------------------
// drst_datapath
// session table, address match, statistics counters and result register
// ----------------------------------------------------------------------------
module drst_datapath (
	input  logic           clk,
	input  logic           arst_n,
	input  drst_pkg::cmd_t cmd,
	input  drst_pkg::msg_t msg,
	output drst_pkg::rpt_t rpt
);
	import drst_pkg::*;

	// captured item and registered lookup
	msg_t msg_s1;
	logic hit_s2;
	idx_t hit_idx_s2;
	logic free_ok_s2;
	idx_t free_idx_s2;

	// session table
	logic [SESSIONS-1:0] valid_q;
	logic [15:0]         tester_q [SESSIONS];
	logic [15:0]         gateway_q [SESSIONS];
	logic [2:0]          link_q [SESSIONS];
	logic [7:0]          code_q [SESSIONS];
	logic                seen_q [SESSIONS];
	count_t              diag_q [SESSIONS];

	count_t cnt_q [N_COUNTERS];
	count_t cnt_nx [N_COUNTERS];
	rpt_t   rpt_q;

	logic [SESSIONS-1:0] hit_v;
	idx_t                hit_idx;
	idx_t                free_idx;

	logic [N_COUNTERS-1:0] bump;
	logic [2:0]            status_d;
	logic                  touch;
	logic                  wr_new;
	logic                  wr_resp;
	logic                  ver_ok;
	idx_t                  tidx;
	logic [2:0]            link_nx;
	count_t                diag_nx;

	// parallel address match, lowest index wins
	always_comb begin
		hit_v    = '0;
		hit_idx  = '0;
		free_idx = '0;
		for (int i = 0; i < SESSIONS; i++) begin
			hit_v[i] = valid_q[i] && (tester_q[i] == msg_s1.addr_first);
		end
		for (int i = SESSIONS - 1; i >= 0; i--) begin
			if (hit_v[i]) begin
				hit_idx = idx_t'(i);
			end
			if (!valid_q[i]) begin
				free_idx = idx_t'(i);
			end
		end
	end

	assign ver_ok = (~msg_s1.version == msg_s1.inverse_version);
	assign tidx   = hit_s2 ? hit_idx_s2 : free_idx_s2;

	// commit decision
	always_comb begin
		bump           = '0;
		bump[C_PACKET] = 1'b1;
		status_d       = ST_OK;
		touch          = 1'b0;
		wr_new         = 1'b0;
		wr_resp        = 1'b0;
		link_nx        = link_q[tidx];
		diag_nx        = diag_q[tidx];
		if (!ver_ok) begin
			bump[C_ERROR] = 1'b1;
			status_d      = ST_BAD_VER;
		end else begin
			unique case (msg_s1.op)
				OP_ROUTE_REQ: begin
					bump[C_REQUEST] = 1'b1;
					if (msg_s1.payload_len < MIN_REQ_LEN) begin
						bump[C_ERROR] = 1'b1;
						status_d      = ST_TOO_SHORT;
					end else if (hit_s2 || free_ok_s2) begin
						touch   = 1'b1;
						wr_new  = !hit_s2;
						link_nx = LS_AWAIT_RESP;
						if (!hit_s2) begin
							diag_nx = '0;
						end
					end else begin
						status_d = ST_TABLE_FULL;
					end
				end
				OP_ROUTE_RESP: begin
					bump[C_RESPONSE] = 1'b1;
					if (msg_s1.payload_len < MIN_RESP_LEN) begin
						bump[C_ERROR] = 1'b1;
						status_d      = ST_TOO_SHORT;
					end else if (hit_s2) begin
						touch   = 1'b1;
						wr_resp = 1'b1;
						priority if (msg_s1.code_byte == CODE_ACTIVATED) begin
							link_nx = LS_ACTIVE;
						end else if (msg_s1.code_byte == CODE_CONFIRM) begin
							link_nx = LS_AWAIT_CONF;
						end else begin
							link_nx = LS_FAILED;
						end
					end else begin
						status_d = ST_NO_MATCH;
					end
				end
				OP_DIAG_MSG: begin
					bump[C_DIAG] = 1'b1;
					if (msg_s1.payload_len < MIN_DIAG_LEN) begin
						bump[C_ERROR] = 1'b1;
						status_d      = ST_TOO_SHORT;
					end else if (hit_s2) begin
						touch   = 1'b1;
						diag_nx = sat_inc(diag_q[tidx]);
					end else begin
						status_d = ST_NO_MATCH;
					end
				end
				OP_ACK_POS, OP_ACK_NEG: begin
					if (msg_s1.payload_len < MIN_ACK_LEN) begin
						status_d = ST_TOO_SHORT;
					end
				end
				OP_ANNOUNCE: begin
					bump[C_ANNOUNCE] = 1'b1;
					if (msg_s1.payload_len < MIN_ANN_LEN) begin
						bump[C_ERROR] = 1'b1;
						status_d      = ST_TOO_SHORT;
					end
				end
				OP_ALIVE_REQ: begin
					bump[C_ALIVE] = 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		for (int k = 0; k < N_COUNTERS; k++) begin
			cnt_nx[k] = bump[k] ? sat_inc(cnt_q[k]) : cnt_q[k];
		end
	end

	// control state: valid bits and statistics
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			for (int k = 0; k < N_COUNTERS; k++) begin
				cnt_q[k] <= '0;
			end
		end else if (cmd.commit) begin
			if (wr_new) begin
				valid_q[tidx] <= 1'b1;
			end
			for (int k = 0; k < N_COUNTERS; k++) begin
				cnt_q[k] <= cnt_nx[k];
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			msg_s1 <= msg;
		end
		if (cmd.lookup) begin
			hit_s2      <= |hit_v;
			hit_idx_s2  <= hit_idx;
			free_ok_s2  <= ~&valid_q;
			free_idx_s2 <= free_idx;
		end
		if (cmd.commit) begin
			if (touch) begin
				link_q[tidx] <= link_nx;
				diag_q[tidx] <= diag_nx;
			end
			if (wr_new) begin
				tester_q[tidx]  <= msg_s1.addr_first;
				gateway_q[tidx] <= '0;
				code_q[tidx]    <= '0;
				seen_q[tidx]    <= 1'b0;
			end
			if (wr_resp) begin
				gateway_q[tidx] <= msg_s1.addr_second;
				code_q[tidx]    <= msg_s1.code_byte;
				seen_q[tidx]    <= 1'b1;
			end
			rpt_q.status         <= status_d;
			rpt_q.session_state  <= touch ? link_nx : LS_NONE;
			rpt_q.diag_count     <= touch ? show(diag_nx) : '0;
			rpt_q.packet_total   <= show(cnt_nx[C_PACKET]);
			rpt_q.request_total  <= show(cnt_nx[C_REQUEST]);
			rpt_q.response_total <= show(cnt_nx[C_RESPONSE]);
			rpt_q.diag_total     <= show(cnt_nx[C_DIAG]);
			rpt_q.alive_total    <= show(cnt_nx[C_ALIVE]);
			rpt_q.announce_total <= show(cnt_nx[C_ANNOUNCE]);
			rpt_q.error_total    <= show(cnt_nx[C_ERROR]);
		end
	end

	assign rpt = rpt_q;

endmodule

// ----- dv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// checks the routing session tracker against a cycle-free session predictor
// ----------------------------------------------------------------------------
// every accepted message is run through a local copy of the session table and
// the statistics counters, and the report it should produce is queued. each
// report taken from the block is compared field by field with the oldest
// queued one. a directed set covers every message kind and the corner cases.
// random traffic follows under several sender and receiver idling mixes, a
// long output hold-off, and a phase with a full session table.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import drst_pkg::*;

	// message kind without a package name
	localparam logic [2:0] OP_OTHER = 3'd7;

	// cycles with no item moving before the run is called hung
	localparam int QUIET_LIMIT = 1000;
	// result latency plus margin, waited out once at the end
	localparam int TAIL_CYCLES = 12;
	// long receiver hold-off of the pressure test
	localparam int HOLD_CYCLES = 150;

	logic clk = 1'b0;
	logic arst_n;
	logic msg_valid;
	logic msg_stall;
	msg_t msg;
	logic rpt_valid;
	logic rpt_stall;
	rpt_t rpt;

	// idling mix of the current phase, in percent
	int send_idle_pct = 0;
	int rpt_stall_pct = 0;
	// request for one long receiver hold-off
	int hold_request = 0;

	int errors = 0;
	int quiet_cycles = 0;

	// reports still owed by the block, oldest first
	rpt_t expected_reports [$];

	// tester addresses the random traffic keeps returning to
	logic [15:0] tester_pool [$];

	// predicted session table and statistics
	logic        sess_used   [SESSIONS];
	logic [15:0] sess_tester [SESSIONS];
	logic [2:0]  sess_link   [SESSIONS];
	count_t      sess_diag   [SESSIONS];
	count_t      stats       [N_COUNTERS];

	always #4 clk = ~clk;

	doip_routing_session_tracker u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.msg_valid (msg_valid),
		.msg_stall (msg_stall),
		.msg       (msg),
		.rpt_valid (rpt_valid),
		.rpt_stall (rpt_stall),
		.rpt       (rpt)
	);

	// ------------------------------------------------------------------
	// session predictor
	// ------------------------------------------------------------------

	// saturating bump of one statistics counter
	function automatic void bump_stat(int slot);
		if (stats[slot] != '1)
			stats[slot] = stats[slot] + 1'b1;
	endfunction

	function automatic int find_session(logic [15:0] tester);
		for (int i = 0; i < SESSIONS; i++)
			if (sess_used[i] && sess_tester[i] == tester)
				return i;
		return -1;
	endfunction

	// lowest free entry, or -1 when the table is full
	function automatic int free_session();
		for (int i = 0; i < SESSIONS; i++)
			if (!sess_used[i])
				return i;
		return -1;
	endfunction

	// applies one message to the predicted state and returns its report
	function automatic rpt_t track_message(msg_t m);
		rpt_t r;
		int   hit;
		int   slot;
		r   = '0;
		hit = -1;
		bump_stat(C_PACKET);
		if (m.inverse_version != ~m.version) begin
			// broken version pair: only the packet and error counters move
			bump_stat(C_ERROR);
			r.status = ST_BAD_VER;
		end else begin
			case (m.op)
				OP_ROUTE_REQ: begin
					bump_stat(C_REQUEST);
					if (m.payload_len < MIN_REQ_LEN) begin
						bump_stat(C_ERROR);
						r.status = ST_TOO_SHORT;
					end else begin
						slot = find_session(m.addr_first);
						if (slot < 0)
							slot = free_session();
						if (slot < 0) begin
							// new tester with no room: dropped, not an error
							r.status = ST_TABLE_FULL;
						end else begin
							if (!sess_used[slot]) begin
								sess_used[slot]   = 1'b1;
								sess_tester[slot] = m.addr_first;
								sess_diag[slot]   = '0;
							end
							// open or re-arm
							sess_link[slot] = LS_AWAIT_RESP;
							hit = slot;
						end
					end
				end
				OP_ROUTE_RESP: begin
					bump_stat(C_RESPONSE);
					if (m.payload_len < MIN_RESP_LEN) begin
						bump_stat(C_ERROR);
						r.status = ST_TOO_SHORT;
					end else begin
						slot = find_session(m.addr_first);
						if (slot < 0) begin
							r.status = ST_NO_MATCH;
						end else begin
							if (m.code_byte == CODE_ACTIVATED)
								sess_link[slot] = LS_ACTIVE;
							else if (m.code_byte == CODE_CONFIRM)
								sess_link[slot] = LS_AWAIT_CONF;
							else
								sess_link[slot] = LS_FAILED;
							hit = slot;
						end
					end
				end
				OP_DIAG_MSG: begin
					bump_stat(C_DIAG);
					if (m.payload_len < MIN_DIAG_LEN) begin
						bump_stat(C_ERROR);
						r.status = ST_TOO_SHORT;
					end else begin
						slot = find_session(m.addr_first);
						if (slot < 0) begin
							r.status = ST_NO_MATCH;
						end else begin
							if (sess_diag[slot] != '1)
								sess_diag[slot] = sess_diag[slot] + 1'b1;
							hit = slot;
						end
					end
				end
				OP_ACK_POS, OP_ACK_NEG: begin
					// short acknowledge is flagged but not counted as an error
					if (m.payload_len < MIN_ACK_LEN)
						r.status = ST_TOO_SHORT;
				end
				OP_ANNOUNCE: begin
					bump_stat(C_ANNOUNCE);
					if (m.payload_len < MIN_ANN_LEN) begin
						bump_stat(C_ERROR);
						r.status = ST_TOO_SHORT;
					end
				end
				OP_ALIVE_REQ: bump_stat(C_ALIVE);
				default: ;
			endcase
		end
		if (hit >= 0) begin
			r.session_state = sess_link[hit];
			r.diag_count    = OUT_BITS'(sess_diag[hit]);
		end else begin
			r.session_state = LS_NONE;
			r.diag_count    = '0;
		end
		r.packet_total   = OUT_BITS'(stats[C_PACKET]);
		r.request_total  = OUT_BITS'(stats[C_REQUEST]);
		r.response_total = OUT_BITS'(stats[C_RESPONSE]);
		r.diag_total     = OUT_BITS'(stats[C_DIAG]);
		r.alive_total    = OUT_BITS'(stats[C_ALIVE]);
		r.announce_total = OUT_BITS'(stats[C_ANNOUNCE]);
		r.error_total    = OUT_BITS'(stats[C_ERROR]);
		return r;
	endfunction

	// ------------------------------------------------------------------
	// message side
	// ------------------------------------------------------------------

	// offers one item, waits for it to be taken, then queues its report.
	// valid stays high afterwards so back-to-back items need no dip
	task automatic send_msg(msg_t m);
		logic taken;
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			msg_valid <= 1'b0;
			@(posedge clk);
		end
		msg_valid <= 1'b1;
		msg       <= m;
		do begin
			// stall only changes at rising edges, so the falling edge shows
			// the value the next edge will act on
			@(negedge clk);
			taken = !msg_stall;
			@(posedge clk);
		end while (!taken);
		expected_reports.push_back(track_message(m));
	endtask

	task automatic park_sender();
		msg_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (expected_reports.size() != 0)
			@(posedge clk);
	endtask

	// well-formed header with the usual version pair
	function automatic msg_t make_msg(logic [2:0] op, logic [15:0] len,
			logic [15:0] first, logic [15:0] second, logic [7:0] code);
		msg_t m;
		m.op              = op;
		m.version         = 8'h02;
		m.inverse_version = 8'hFD;
		m.payload_len     = len;
		m.addr_first      = first;
		m.addr_second     = second;
		m.code_byte       = code;
		return m;
	endfunction

	// mostly good headers aimed at known testers, with some noise on top
	function automatic msg_t random_message(bit allow_new);
		msg_t m;
		int   pick;
		pick = $urandom_range(99);
		if (pick < 25)
			m.op = OP_ROUTE_REQ;
		else if (pick < 45)
			m.op = OP_ROUTE_RESP;
		else if (pick < 65)
			m.op = OP_DIAG_MSG;
		else
			m.op = 3'($urandom_range(OP_ACK_POS, OP_OTHER));
		m.version = 8'($urandom);
		if ($urandom_range(99) < 10)
			m.inverse_version = 8'($urandom);
		else
			m.inverse_version = ~m.version;
		pick = $urandom_range(99);
		if (pick < 20)
			m.payload_len = 16'($urandom_range(0, 40));
		else if (pick < 30)
			m.payload_len = 16'($urandom);
		else
			m.payload_len = 16'($urandom_range(32, 4000));
		// requests stay inside the pool until the table is meant to fill
		if ($urandom_range(99) < 85 || (m.op == OP_ROUTE_REQ && !allow_new))
			m.addr_first = tester_pool[$urandom_range(tester_pool.size() - 1)];
		else
			m.addr_first = 16'($urandom);
		m.addr_second = 16'($urandom);
		pick = $urandom_range(99);
		if (pick < 40)
			m.code_byte = CODE_ACTIVATED;
		else if (pick < 60)
			m.code_byte = CODE_CONFIRM;
		else
			m.code_byte = 8'($urandom);
		return m;
	endfunction

	task automatic run_random(int count, bit allow_new);
		for (int i = 0; i < count; i++)
			send_msg(random_message(allow_new));
	endtask

	// ------------------------------------------------------------------
	// report side
	// ------------------------------------------------------------------

	// receiver: random stalls, or one long hold-off when asked
	initial begin
		int n;
		rpt_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request != 0) begin
				n = hold_request;
				hold_request = 0;
				repeat (n) begin
					rpt_stall <= 1'b1;
					@(posedge clk);
				end
			end
			rpt_stall <= (rpt_stall_pct != 0 && $urandom_range(99) < rpt_stall_pct);
		end
	end

	task automatic compare_field(string field, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s expected %0h got %0h", $time, field, want, got);
		end
	endtask

	// a report moves at the next rising edge; its value is stable here
	always @(negedge clk) begin
		rpt_t want;
		if (arst_n === 1'b1 && rpt_valid === 1'b1 && rpt_stall === 1'b0) begin
			if (expected_reports.size() == 0) begin
				errors++;
				$display("%0t: report with none expected, got %h", $time, rpt);
			end else begin
				want = expected_reports.pop_front();
				compare_field("status", 32'(want.status), 32'(rpt.status));
				compare_field("session_state", 32'(want.session_state),
					32'(rpt.session_state));
				compare_field("diag_count", want.diag_count, rpt.diag_count);
				compare_field("packet_total", want.packet_total, rpt.packet_total);
				compare_field("request_total", want.request_total, rpt.request_total);
				compare_field("response_total", want.response_total,
					rpt.response_total);
				compare_field("diag_total", want.diag_total, rpt.diag_total);
				compare_field("alive_total", want.alive_total, rpt.alive_total);
				compare_field("announce_total", want.announce_total,
					rpt.announce_total);
				compare_field("error_total", want.error_total, rpt.error_total);
			end
		end
	end

	// watchdog: too long with no item moving on either side
	always @(negedge clk) begin
		if (arst_n !== 1'b1 || (msg_valid && !msg_stall) || (rpt_valid && !rpt_stall)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no item moved for %0d cycles", $time, quiet_cycles);
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// every message kind, length minima, version checks, address extremes
	task automatic test_directed();
		msg_t m;
		send_idle_pct = 0;
		rpt_stall_pct = 0;
		// broken version pairs, including one with both bytes all ones
		m = make_msg(OP_ROUTE_REQ, 16'd100, 16'h0000, 16'h0000, 8'h00);
		m.version = 8'h02;
		m.inverse_version = 8'h02;
		send_msg(m);
		m.version = 8'hFF;
		m.inverse_version = 8'hFF;
		send_msg(m);
		// good pair at the byte extremes
		m.version = 8'h00;
		m.inverse_version = 8'hFF;
		send_msg(m);
		// request just below and at its minimum
		send_msg(make_msg(OP_ROUTE_REQ, MIN_REQ_LEN - 16'd1, 16'h0000, 16'h0000, 8'h00));
		send_msg(make_msg(OP_ROUTE_REQ, MIN_REQ_LEN, 16'h0000, 16'h0000, 8'h00));
		// response for an unknown tester, then a short one
		send_msg(make_msg(OP_ROUTE_RESP, MIN_RESP_LEN, 16'h1234, 16'h0E00, CODE_ACTIVATED));
		send_msg(make_msg(OP_ROUTE_RESP, MIN_RESP_LEN - 16'd1, 16'h0000, 16'h0E00,
			CODE_ACTIVATED));
		// each response code class on a live session, then re-arm
		send_msg(make_msg(OP_ROUTE_RESP, MIN_RESP_LEN, 16'h0000, 16'h0E00, CODE_ACTIVATED));
		send_msg(make_msg(OP_ROUTE_RESP, MIN_RESP_LEN, 16'h0000, 16'h0E01, CODE_CONFIRM));
		send_msg(make_msg(OP_ROUTE_RESP, MIN_RESP_LEN, 16'h0000, 16'hFFFF, 8'hFF));
		send_msg(make_msg(OP_ROUTE_REQ, MIN_REQ_LEN, 16'h0000, 16'h0000, 8'h00));
		// diagnostic messages: short, counted, unknown tester
		send_msg(make_msg(OP_DIAG_MSG, MIN_DIAG_LEN - 16'd1, 16'h0000, 16'h0000, 8'h00));
		send_msg(make_msg(OP_DIAG_MSG, MIN_DIAG_LEN, 16'h0000, 16'h0E00, 8'h00));
		send_msg(make_msg(OP_DIAG_MSG, MIN_DIAG_LEN, 16'h0000, 16'h0E00, 8'h00));
		send_msg(make_msg(OP_DIAG_MSG, MIN_DIAG_LEN, 16'h4321, 16'h0E00, 8'h00));
		// acknowledges: zero length, just short, at minimum
		send_msg(make_msg(OP_ACK_POS, 16'd0, 16'h0000, 16'h0000, 8'h00));
		send_msg(make_msg(OP_ACK_POS, MIN_ACK_LEN - 16'd1, 16'h0000, 16'h0000, 8'h00));
		send_msg(make_msg(OP_ACK_NEG, MIN_ACK_LEN, 16'h0000, 16'h0000, 8'h00));
		// announcements around their minimum
		send_msg(make_msg(OP_ANNOUNCE, MIN_ANN_LEN - 16'd1, 16'h0000, 16'h0000, 8'h00));
		send_msg(make_msg(OP_ANNOUNCE, MIN_ANN_LEN, 16'h0000, 16'h0000, 8'h00));
		// alive check counts as packet and alive; unlisted kind only as a packet
		send_msg(make_msg(OP_ALIVE_REQ, 16'd0, 16'h0000, 16'h0000, 8'h00));
		send_msg(make_msg(OP_OTHER, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF));
		// all-ones tester with maximum length
		send_msg(make_msg(OP_ROUTE_REQ, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF));
		send_msg(make_msg(OP_ROUTE_RESP, 16'hFFFF, 16'hFFFF, 16'hFFFF, CODE_ACTIVATED));
		send_msg(make_msg(OP_DIAG_MSG, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF));
	endtask

	task automatic test_back_to_back();
		send_idle_pct = 0;
		rpt_stall_pct = 0;
		run_random(250, 1'b0);
	endtask

	task automatic test_sender_idle();
		send_idle_pct = 70;
		rpt_stall_pct = 0;
		run_random(150, 1'b0);
	endtask

	task automatic test_receiver_stall();
		send_idle_pct = 0;
		rpt_stall_pct = 70;
		run_random(150, 1'b0);
	endtask

	task automatic test_both_idle();
		send_idle_pct = 31;
		rpt_stall_pct = 31;
		run_random(150, 1'b0);
	endtask

	// output held off while items keep coming, so the block backs up and
	// stalls its input; then the sender waits until every report is back
	task automatic test_output_hold();
		send_idle_pct = 0;
		rpt_stall_pct = 0;
		hold_request = HOLD_CYCLES;
		run_random(12, 1'b0);
		park_sender();
		wait_drained();
	endtask

	// new testers until the table runs out, then mixed traffic on a full table
	task automatic test_table_full();
		send_idle_pct = 0;
		rpt_stall_pct = 0;
		for (int i = 0; i < 20; i++)
			send_msg(make_msg(OP_ROUTE_REQ, MIN_REQ_LEN, 16'hD000 + 16'(i), 16'h0000, 8'h00));
		send_msg(make_msg(OP_DIAG_MSG, MIN_DIAG_LEN, 16'hD000, 16'h0000, 8'h00));
		send_msg(make_msg(OP_ROUTE_RESP, MIN_RESP_LEN, 16'hD005, 16'h0E00, CODE_ACTIVATED));
		send_idle_pct = 31;
		rpt_stall_pct = 31;
		run_random(170, 1'b1);
	endtask

	initial begin
		arst_n    <= 1'b0;
		msg_valid <= 1'b0;
		msg       <= '0;
		for (int i = 0; i < SESSIONS; i++) begin
			sess_used[i] = 1'b0;
			sess_link[i] = LS_NONE;
			sess_diag[i] = '0;
		end
		for (int i = 0; i < N_COUNTERS; i++)
			stats[i] = '0;
		// 14 testers: the two address extremes plus twelve with distinct top
		// nibbles, leaving two free entries for the full-table test
		tester_pool.push_back(16'h0000);
		tester_pool.push_back(16'hFFFF);
		for (int i = 1; i <= 12; i++)
			tester_pool.push_back({4'(i), 12'($urandom)});
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_back_to_back();
		test_sender_idle();
		test_receiver_stall();
		test_both_idle();
		test_output_hold();
		test_table_full();

		park_sender();
		wait_drained();
		// catch any stray report after the last expected one
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
